>>> rtl/core/assert_macros.svh
// Assertion macros used by the parser module of the MQTT header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, suspended while rst is high.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clk edge, including during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mqttp_pkg.sv
// Types, codes and constants shared by the MQTT header parser files.
`default_nettype none

package mqttp_pkg;

  // Parse phase of the byte walker.
  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_LEN    = 4'd1,
    PH_TLEN   = 4'd2,
    PH_TOPIC  = 4'd3,
    PH_PID    = 4'd4,
    PH_PAYL   = 4'd5,
    PH_LEVEL  = 4'd6,
    PH_CFLAGS = 4'd7,
    PH_KEEP   = 4'd8,
    PH_CIDHI  = 4'd9,
    PH_CIDLO  = 4'd10,
    PH_CID    = 4'd11,
    PH_QOS    = 4'd12,
    PH_OTHER  = 4'd13
  } phase_t;

  // Role tag attached to every byte.
  typedef enum logic [3:0] {
    ROLE_HEADER     = 4'd0,
    ROLE_LEN_DIGIT  = 4'd1,
    ROLE_NAME_LEN   = 4'd2,
    ROLE_NAME       = 4'd3,
    ROLE_PACKET_ID  = 4'd4,
    ROLE_PAYLOAD    = 4'd5,
    ROLE_LEVEL_FLAG = 4'd6,
    ROLE_KEEP_ALIVE = 4'd7,
    ROLE_CLIENT_ID  = 4'd8,
    ROLE_QOS        = 4'd9,
    ROLE_OTHER      = 4'd10
  } role_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  localparam logic [3:0] TYPE_CONNECT   = 4'd1;
  localparam logic [3:0] TYPE_PUBLISH   = 4'd3;
  localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;

  localparam int BYTE_W   = 8;
  localparam int NIBBLE_W = 4;
  localparam int RLEN_W   = 28;
  localparam int FIELD_W  = 16;

  // One tagged byte with the decoded header fields.
  typedef struct packed {
    role_t                 byte_role;
    logic [BYTE_W-1:0]     data_echo;
    logic [NIBBLE_W-1:0]   packet_type;
    logic [NIBBLE_W-1:0]   packet_flags;
    logic [RLEN_W-1:0]     remaining_len;
    logic [FIELD_W-1:0]    name_len;
    logic [FIELD_W-1:0]    packet_id;
    logic [FIELD_W-1:0]    keep_alive;
    status_t               status;
    logic                  packet_end;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mqttp_stream_if.sv
// Valid/ready channel that carries the incoming stream bytes.
`default_nettype none

interface mqttp_stream_if;
  import mqttp_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   data_byte;
  logic                buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mqttp_result_if.sv
// Valid/ready channel that carries one tagged byte and the decoded fields.
`default_nettype none

interface mqttp_result_if;
  import mqttp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [3:0]            byte_role;
  logic [BYTE_W-1:0]     data_echo;
  logic [NIBBLE_W-1:0]   packet_type;
  logic [NIBBLE_W-1:0]   packet_flags;
  logic [RLEN_W-1:0]     remaining_len;
  logic [FIELD_W-1:0]    name_len;
  logic [FIELD_W-1:0]    packet_id;
  logic [FIELD_W-1:0]    keep_alive;
  logic [1:0]            status;
  logic                  packet_end;

  modport source (
    output valid, output byte_role, output data_echo, output packet_type,
    output packet_flags, output remaining_len, output name_len, output packet_id,
    output keep_alive, output status, output packet_end, input ready
  );
  modport sink (
    input valid, input byte_role, input data_echo, input packet_type,
    input packet_flags, input remaining_len, input name_len, input packet_id,
    input keep_alive, input status, input packet_end, output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/mqttp_parser.sv
// Phase machine and held fields of the MQTT header parser, one byte per advance.
`default_nettype none
`include "assert_macros.svh"

module mqttp_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    buffer_last,
  output mqttp_pkg::result_t           result
);
  import mqttp_pkg::*;

  phase_t                phase, phase_next;
  logic [FIELD_W-1:0]    field_count, field_count_next;
  logic [RLEN_W-1:0]     bytes_left, bytes_left_next;
  logic [1:0]            digit_idx, digit_idx_next;
  logic [NIBBLE_W-1:0]   held_type, held_type_next;
  logic [NIBBLE_W-1:0]   held_flags, held_flags_next;
  logic [FIELD_W-1:0]    held_name_len, held_name_len_next;
  logic [FIELD_W-1:0]    held_packet_id, held_packet_id_next;
  logic [FIELD_W-1:0]    held_keep_alive, held_keep_alive_next;
  logic [RLEN_W-1:0]     held_rem_len, held_rem_len_next;

  logic [RLEN_W-1:0]     digit_shifted;
  logic [RLEN_W-1:0]     rem_sum;
  logic [RLEN_W-1:0]     bytes_left_dec;
  logic [FIELD_W-1:0]    field_dec;
  logic [FIELD_W-1:0]    topic_merged;
  logic [FIELD_W-1:0]    cid_merged;
  logic                  natural_end;
  logic                  len_err;
  role_t                 role;
  status_t               status;

  // Phase that follows a topic or protocol name.
  function automatic phase_t after_topic(input logic [3:0] ptype, input logic [3:0] pflags);
    phase_t ph;
    if (ptype == TYPE_CONNECT) begin
      ph = PH_LEVEL;
    end else if (ptype == TYPE_SUBSCRIBE) begin
      ph = PH_QOS;
    end else if (pflags[2:1] != 2'd0) begin
      ph = PH_PID;
    end else begin
      ph = PH_PAYL;
    end
    return ph;
  endfunction

  function automatic phase_t first_body(input logic [3:0] ptype);
    phase_t ph;
    if (ptype == TYPE_CONNECT || ptype == TYPE_PUBLISH) begin
      ph = PH_TLEN;
    end else if (ptype == TYPE_SUBSCRIBE) begin
      ph = PH_PID;
    end else begin
      ph = PH_OTHER;
    end
    return ph;
  endfunction

  // Length digits arrive least significant first, seven bits each.
  always_comb begin
    case (digit_idx)
      2'd0:    digit_shifted = {21'd0, data_byte[6:0]};
      2'd1:    digit_shifted = {14'd0, data_byte[6:0], 7'd0};
      2'd2:    digit_shifted = {7'd0, data_byte[6:0], 14'd0};
      default: digit_shifted = {data_byte[6:0], 21'd0};
    endcase
  end

  assign rem_sum        = held_rem_len + digit_shifted;
  assign bytes_left_dec = (bytes_left != '0) ? bytes_left - 28'd1 : '0;
  assign field_dec      = (field_count != '0) ? field_count - 16'd1 : '0;
  assign topic_merged   = held_name_len | {8'd0, data_byte};
  assign cid_merged     = field_count | {8'd0, data_byte};

  // Next state.
  always_comb begin
    phase_next           = phase;
    field_count_next     = field_count;
    bytes_left_next      = bytes_left;
    digit_idx_next       = digit_idx;
    held_type_next       = held_type;
    held_flags_next      = held_flags;
    held_name_len_next   = held_name_len;
    held_packet_id_next  = held_packet_id;
    held_keep_alive_next = held_keep_alive;
    held_rem_len_next    = held_rem_len;
    natural_end          = 1'b0;
    len_err              = 1'b0;

    case (phase)
      PH_HDR: begin
        held_type_next       = data_byte[7:4];
        held_flags_next      = data_byte[3:0];
        held_name_len_next   = '0;
        held_packet_id_next  = '0;
        held_keep_alive_next = '0;
        held_rem_len_next    = '0;
        digit_idx_next       = '0;
        bytes_left_next      = '0;
        field_count_next     = '0;
        phase_next           = PH_LEN;
      end
      PH_LEN: begin
        held_rem_len_next = rem_sum;
        if (data_byte[7]) begin
          if (digit_idx == 2'd3) begin
            len_err     = 1'b1;
            natural_end = 1'b1;
          end else begin
            digit_idx_next = digit_idx + 2'd1;
          end
        end else begin
          bytes_left_next  = rem_sum;
          field_count_next = '0;
          if (rem_sum == '0) begin
            natural_end = 1'b1;
          end else begin
            phase_next = first_body(held_type);
          end
        end
      end
      default: begin
        bytes_left_next = bytes_left_dec;
        natural_end     = (bytes_left_dec == '0);
        case (phase)
          PH_TLEN: begin
            if (field_count == '0) begin
              held_name_len_next = {data_byte, 8'd0};
              field_count_next   = 16'd1;
            end else begin
              held_name_len_next = topic_merged;
              if (topic_merged != '0) begin
                field_count_next = topic_merged;
                phase_next       = PH_TOPIC;
              end else begin
                field_count_next = '0;
                phase_next       = after_topic(held_type, held_flags);
              end
            end
          end
          PH_TOPIC: begin
            field_count_next = field_dec;
            if (field_dec == '0) begin
              phase_next = after_topic(held_type, held_flags);
            end
          end
          PH_PID: begin
            if (field_count == '0) begin
              held_packet_id_next = {data_byte, 8'd0};
              field_count_next    = 16'd1;
            end else begin
              held_packet_id_next = held_packet_id | {8'd0, data_byte};
              field_count_next    = '0;
              phase_next = (held_type == TYPE_SUBSCRIBE) ? PH_TLEN : PH_PAYL;
            end
          end
          PH_LEVEL: begin
            phase_next = PH_CFLAGS;
          end
          PH_CFLAGS: begin
            field_count_next = '0;
            phase_next       = PH_KEEP;
          end
          PH_KEEP: begin
            if (field_count == '0) begin
              held_keep_alive_next = {data_byte, 8'd0};
              field_count_next     = 16'd1;
            end else begin
              held_keep_alive_next = held_keep_alive | {8'd0, data_byte};
              field_count_next     = '0;
              phase_next           = PH_CIDHI;
            end
          end
          PH_CIDHI: begin
            field_count_next = {data_byte, 8'd0};
            phase_next       = PH_CIDLO;
          end
          PH_CIDLO: begin
            field_count_next = cid_merged;
            phase_next       = (cid_merged != '0) ? PH_CID : PH_OTHER;
          end
          PH_CID: begin
            field_count_next = field_dec;
            if (field_dec == '0) begin
              phase_next = PH_OTHER;
            end
          end
          PH_QOS: begin
            field_count_next = '0;
            phase_next       = PH_TLEN;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    endcase

    // Any end of packet, natural or forced by the buffer end, returns to header.
    if (natural_end || buffer_last) begin
      phase_next = PH_HDR;
    end
  end

  // Outputs.
  always_comb begin
    case (phase)
      PH_HDR:              role = ROLE_HEADER;
      PH_LEN:              role = ROLE_LEN_DIGIT;
      PH_TLEN:             role = ROLE_NAME_LEN;
      PH_TOPIC:            role = ROLE_NAME;
      PH_PID:              role = ROLE_PACKET_ID;
      PH_PAYL:             role = ROLE_PAYLOAD;
      PH_LEVEL, PH_CFLAGS: role = ROLE_LEVEL_FLAG;
      PH_KEEP:             role = ROLE_KEEP_ALIVE;
      PH_CIDHI, PH_CIDLO,
      PH_CID:              role = ROLE_CLIENT_ID;
      PH_QOS:              role = ROLE_QOS;
      default:             role = ROLE_OTHER;
    endcase

    // A length error outranks truncation; truncation only hits a byte that
    // does not already end the packet.
    if (len_err) begin
      status = ST_LEN_ERR;
    end else if (!natural_end && buffer_last) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end

    result.byte_role     = role;
    result.data_echo     = data_byte;
    result.packet_type   = held_type_next;
    result.packet_flags  = held_flags_next;
    result.remaining_len = held_rem_len_next;
    result.name_len      = held_name_len_next;
    result.packet_id     = held_packet_id_next;
    result.keep_alive    = held_keep_alive_next;
    result.status        = status;
    result.packet_end    = natural_end || buffer_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      field_count     <= '0;
      bytes_left      <= '0;
      digit_idx       <= '0;
      held_type       <= '0;
      held_flags      <= '0;
      held_name_len   <= '0;
      held_packet_id  <= '0;
      held_keep_alive <= '0;
      held_rem_len    <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      field_count     <= field_count_next;
      bytes_left      <= bytes_left_next;
      digit_idx       <= digit_idx_next;
      held_type       <= held_type_next;
      held_flags      <= held_flags_next;
      held_name_len   <= held_name_len_next;
      held_packet_id  <= held_packet_id_next;
      held_keep_alive <= held_keep_alive_next;
      held_rem_len    <= held_rem_len_next;
    end
  end

  `ASSERT_CLK_RST(a_end_returns_to_header,
    advance && result.packet_end |=> phase == PH_HDR,
    "parser did not return to header phase after a packet end")
  `ASSERT_CLK_RST(a_header_then_length,
    advance && phase == PH_HDR && !buffer_last |=> phase == PH_LEN,
    "header byte was not followed by the length phase")
  `ASSERT_CLK_RST(a_body_count_falls,
    advance && phase != PH_HDR && phase != PH_LEN |=> bytes_left <= $past(bytes_left),
    "body byte count grew while walking a packet body")

endmodule

`default_nettype wire

>>> rtl/core/mqtt_packet_header_parser_top.sv
// Top level of the MQTT 3.1.1 packet header parser with its stream and result channels.
`default_nettype none

// The block takes an MQTT byte stream one byte per request on the stream
// channel and returns exactly one result request per byte on the result
// channel: the byte echoed, its role in the packet, and the header fields
// decoded so far (type, flags, remaining length, topic or protocol name length,
// packet identifier and CONNECT keep-alive). The fixed header length is a
// base-128 varint of one to four digits; a continuation bit on the fourth
// digit reports a length error and ends the packet. A byte flagged as the
// buffer end that does not close the packet reports truncation and ends it.
// After any end the next byte is taken as a fresh header byte. Throughput
// is one byte per clock cycle while results are taken: every byte passes an
// input register, one short step of the phase machine, and an output
// register, from which its result is offered on the result channel.
// The input register keeps accepting while a finished result waits to be
// taken, and the stream is only held off when both registers are occupied
// and the waiting result is not taken in that cycle.
// There is no configuration and no start-up pass after reset.

module mqtt_packet_header_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  mqttp_stream_if.sink    stream,
  mqttp_result_if.source  result
);
  import mqttp_pkg::*;

  // Input register.
  logic                in_valid;
  logic [BYTE_W-1:0]   in_byte;
  logic                in_last;

  // Output register.
  logic                out_valid;
  result_t             out_res;

  result_t             step_res;
  logic                advance;

  // A byte moves from the input register into the parser whenever the
  // output register is empty or is being drained in this cycle.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  mqttp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .data_byte   (in_byte),
    .buffer_last (in_last),
    .result      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
      in_last <= stream.buffer_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.byte_role     = out_res.byte_role;
  assign result.data_echo     = out_res.data_echo;
  assign result.packet_type   = out_res.packet_type;
  assign result.packet_flags  = out_res.packet_flags;
  assign result.remaining_len = out_res.remaining_len;
  assign result.name_len      = out_res.name_len;
  assign result.packet_id     = out_res.packet_id;
  assign result.keep_alive    = out_res.keep_alive;
  assign result.status        = out_res.status;
  assign result.packet_end    = out_res.packet_end;

endmodule

`default_nettype wire
